### rtl/core/pfj_pkg.sv
// ----------------------------------------------------------------------------
// pfj_pkg
// Shared widths, word types and operand helpers for the power flow jacobian
// element pipeline.
// ----------------------------------------------------------------------------
package pfj_pkg;

  localparam int DW     = 32;          // data width, two's complement
  localparam int FB     = 16;          // fraction bits
  localparam int OPW    = DW + 1;      // multiplier operand width, holds a negated minimum
  localparam int PRW    = 2 * OPW;     // full product width
  localparam int SUMW   = 2 * DW;      // width of re^2 + im^2
  localparam int QW     = FB + 1;      // unit vector quotient width
  localparam int CM_LAT = 2;           // complex multiply-round latency
  localparam int UV_LAT = DW + FB + 4; // unit vector latency
  localparam int OUT_T  = UV_LAT + 2 * CM_LAT; // input register to output register

  typedef logic signed [DW-1:0]  data_t;
  typedef logic signed [OPW-1:0] opnd_t;

  typedef enum logic {
    OP_OFFDIAG = 1'b0,
    OP_DIAG    = 1'b1
  } op_t;

  typedef struct packed {
    op_t   operation;
    data_t adm_re;
    data_t adm_im;
    data_t vrow_re;
    data_t vrow_im;
    data_t vcol_re;
    data_t vcol_im;
    data_t cur_re;
    data_t cur_im;
  } in_word_t;

  typedef struct packed {
    data_t angle_re;
    data_t angle_im;
    data_t mag_re;
    data_t mag_im;
  } out_word_t;

  typedef struct packed {
    data_t re;
    data_t im;
  } cplx_t;

  // sign extend to operand width
  function automatic opnd_t ext(input data_t x);
    return opnd_t'(x);
  endfunction

  // negate at operand width, no overflow
  function automatic opnd_t neg(input data_t x);
    return -opnd_t'(x);
  endfunction

endpackage

### rtl/core/pfj_cmul.sv
// ----------------------------------------------------------------------------
// pfj_cmul
// Two sums of two products, rounded half up to the fraction point and
// saturated. Products registered, then sum, round and clamp registered.
// ----------------------------------------------------------------------------
module pfj_cmul (
  input  logic          clk,
  input  logic          en,
  input  pfj_pkg::opnd_t a,
  input  pfj_pkg::opnd_t b,
  input  pfj_pkg::opnd_t c,
  input  pfj_pkg::opnd_t d,
  input  pfj_pkg::opnd_t e,
  input  pfj_pkg::opnd_t f,
  input  pfj_pkg::opnd_t g,
  input  pfj_pkg::opnd_t h,
  output pfj_pkg::data_t re_r,
  output pfj_pkg::data_t im_r
);

  localparam int ACCW = pfj_pkg::PRW + 1;
  localparam logic signed [ACCW-1:0] HALF  = ACCW'(1) << (pfj_pkg::FB - 1);
  localparam logic signed [ACCW-1:0] MAX_A =
    {{(ACCW - pfj_pkg::DW + 1){1'b0}}, {(pfj_pkg::DW - 1){1'b1}}};
  localparam logic signed [ACCW-1:0] MIN_A =
    {{(ACCW - pfj_pkg::DW + 1){1'b1}}, {(pfj_pkg::DW - 1){1'b0}}};
  localparam pfj_pkg::data_t MAX_D = {1'b0, {(pfj_pkg::DW - 1){1'b1}}};
  localparam pfj_pkg::data_t MIN_D = {1'b1, {(pfj_pkg::DW - 1){1'b0}}};

  logic signed [pfj_pkg::PRW-1:0] prod_r [4];
  pfj_pkg::data_t re_nxt, im_nxt;

  function automatic pfj_pkg::data_t rnd_sat(input logic signed [pfj_pkg::PRW-1:0] p,
                                             input logic signed [pfj_pkg::PRW-1:0] q);
    logic signed [ACCW-1:0] s;
    logic signed [ACCW-1:0] t;
    s = ACCW'(p) + ACCW'(q) + HALF;
    t = s >>> pfj_pkg::FB;
    if (t > MAX_A) return MAX_D;
    else if (t < MIN_A) return MIN_D;
    else return t[pfj_pkg::DW-1:0];
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= a * b;
      prod_r[1] <= c * d;
      prod_r[2] <= e * f;
      prod_r[3] <= g * h;
    end
  end

  // sum, round, saturate
  always_comb begin
    re_nxt = rnd_sat(prod_r[0], prod_r[1]);
    im_nxt = rnd_sat(prod_r[2], prod_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

endmodule

### rtl/core/pfj_unitvec.sv
// ----------------------------------------------------------------------------
// pfj_unitvec
// Unit vector V / max(|V|, 1 LSB): squared magnitude, one root bit per stage,
// then one quotient bit per stage for both components, rounded half away
// from zero.
// ----------------------------------------------------------------------------
module pfj_unitvec (
  input  logic           clk,
  input  logic           en,
  input  pfj_pkg::data_t x_re,
  input  pfj_pkg::data_t x_im,
  output pfj_pkg::data_t n_re_r,
  output pfj_pkg::data_t n_im_r
);

  localparam int DW   = pfj_pkg::DW;
  localparam int FB   = pfj_pkg::FB;
  localparam int SUMW = pfj_pkg::SUMW;
  localparam int QW   = pfj_pkg::QW;

  // squares and sum
  logic [SUMW-1:0] sq_r [2];
  logic [SUMW-1:0] sum_r;
  pfj_pkg::data_t  xa_r [2];
  pfj_pkg::data_t  xb_r [2];

  // root stages
  logic [SUMW-1:0] op_r  [DW];
  logic [SUMW-1:0] res_r [DW];
  logic [SUMW-1:0] op_nxt  [DW];
  logic [SUMW-1:0] res_nxt [DW];
  pfj_pkg::data_t  xs_r [DW][2];

  // divide stages, index 0 is the integer bit
  logic [DW-1:0] dm_r [FB+1];
  logic [DW-1:0] dr_r [FB+1][2];
  logic [QW-1:0] dq_r [FB+1][2];
  logic          ds_r [FB+1][2];
  logic [DW-1:0] dr_nxt [FB+1][2];
  logic [QW-1:0] dq_nxt [FB+1][2];
  logic [DW-1:0] m0;
  pfj_pkg::data_t n_nxt [2];

  function automatic logic [DW-1:0] uabs(input pfj_pkg::data_t x);
    logic [DW-1:0] u;
    u = x;
    return x[DW-1] ? (~u + 1'b1) : u;
  endfunction

  // squared magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= SUMW'(uabs(x_re)) * SUMW'(uabs(x_re));
      sq_r[1] <= SUMW'(uabs(x_im)) * SUMW'(uabs(x_im));
      xa_r[0] <= x_re;
      xa_r[1] <= x_im;
      sum_r   <= sq_r[0] + sq_r[1];
      xb_r    <= xa_r;
    end
  end

  // one root bit per stage
  always_comb begin
    logic [SUMW-1:0] s_op;
    logic [SUMW-1:0] s_res;
    logic [SUMW-1:0] one;
    logic [SUMW:0]   trial;
    for (int i = 0; i < DW; i++) begin
      s_op  = (i == 0) ? sum_r : op_r[(i == 0) ? 0 : i - 1];
      s_res = (i == 0) ? '0 : res_r[(i == 0) ? 0 : i - 1];
      one   = {{(SUMW-1){1'b0}}, 1'b1} << (SUMW - 2 - 2 * i);
      trial = {1'b0, s_res} + {1'b0, one};
      if ({1'b0, s_op} >= trial) begin
        op_nxt[i]  = s_op - trial[SUMW-1:0];
        res_nxt[i] = (s_res >> 1) + one;
      end else begin
        op_nxt[i]  = s_op;
        res_nxt[i] = s_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DW; i++) begin
        op_r[i]  <= op_nxt[i];
        res_r[i] <= res_nxt[i];
        if (i == 0) begin
          xs_r[i] <= xb_r;
        end else begin
          xs_r[i] <= xs_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // zero magnitude counts as one lsb
  assign m0 = (res_r[DW-1][DW-1:0] == '0) ? DW'(1) : res_r[DW-1][DW-1:0];

  // restoring divide, one quotient bit per stage
  always_comb begin
    logic [DW-1:0] ax;
    logic [DW:0]   r2;
    logic          ge;
    for (int l = 0; l < 2; l++) begin
      ax = uabs(xs_r[DW-1][l]);
      ge = (ax >= m0);
      dr_nxt[0][l] = ge ? (ax - m0) : ax;
      dq_nxt[0][l] = QW'(ge);
      for (int j = 1; j <= FB; j++) begin
        r2 = {dr_r[j-1][l], 1'b0};
        ge = (r2 >= {1'b0, dm_r[j-1]});
        dr_nxt[j][l] = ge ? DW'(r2 - {1'b0, dm_r[j-1]}) : r2[DW-1:0];
        dq_nxt[j][l] = {dq_r[j-1][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= m0;
      for (int l = 0; l < 2; l++) begin
        dr_r[0][l] <= dr_nxt[0][l];
        dq_r[0][l] <= dq_nxt[0][l];
        ds_r[0][l] <= xs_r[DW-1][l][DW-1];
      end
      for (int j = 1; j <= FB; j++) begin
        dm_r[j] <= dm_r[j-1];
        for (int l = 0; l < 2; l++) begin
          dr_r[j][l] <= dr_nxt[j][l];
          dq_r[j][l] <= dq_nxt[j][l];
          ds_r[j][l] <= ds_r[j-1][l];
        end
      end
    end
  end

  // round half away from zero and restore sign
  always_comb begin
    logic [QW-1:0] q;
    for (int l = 0; l < 2; l++) begin
      q = dq_r[FB][l];
      if ({dr_r[FB][l], 1'b0} >= {1'b0, dm_r[FB]}) q = q + 1'b1;
      n_nxt[l] = ds_r[FB][l] ? -pfj_pkg::data_t'(DW'(q)) : pfj_pkg::data_t'(DW'(q));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_re_r <= n_nxt[0];
      n_im_r <= n_nxt[1];
    end
  end

endmodule

### rtl/core/power_flow_jacobian_element.sv
// ----------------------------------------------------------------------------
// power_flow_jacobian_element
// Polar Newton-Raphson jacobian contributions for one admittance nonzero or
// one bus diagonal, complex Q15.16 with saturation.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word, in
// order, through the input register, the unit vector and then two complex
// multiply-round units. The latency is set by the voltage unit vector: 32
// root stages, one bit each, and 17 quotient stages. While a result waits
// at the output the whole pipeline holds and in_ready is low; otherwise a
// new word is taken every cycle.
module power_flow_jacobian_element (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfj_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfj_pkg::out_word_t  out_data
);

  localparam int UV    = pfj_pkg::UV_LAT;
  localparam int OUT_T = pfj_pkg::OUT_T;
  localparam int PAY_D = UV + pfj_pkg::CM_LAT;

  logic en;
  logic v_r [OUT_T+1];
  pfj_pkg::in_word_t pay_r [PAY_D+1];
  pfj_pkg::cplx_t    ang_d_r [UV];
  pfj_pkg::cplx_t    n_d_r [pfj_pkg::CM_LAT];

  pfj_pkg::data_t uv_x_re, uv_x_im, n_re, n_im;
  pfj_pkg::data_t p_re, p_im, a_re, a_im, q_re, q_im, m_re, m_im;
  pfj_pkg::opnd_t ao [8];
  pfj_pkg::opnd_t mo [8];
  pfj_pkg::in_word_t pa, pm;

  // whole pipeline advances unless the output word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[OUT_T];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= OUT_T; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= OUT_T; i++) v_r[i] <= v_r[i-1];
    end
  end

  // payload delay line
  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= in_data;
      for (int i = 1; i <= PAY_D; i++) pay_r[i] <= pay_r[i-1];
    end
  end

  // unit vector of the column voltage, or the bus voltage on a diagonal
  assign uv_x_re = (pay_r[0].operation == pfj_pkg::OP_DIAG) ? pay_r[0].vrow_re
                                                            : pay_r[0].vcol_re;
  assign uv_x_im = (pay_r[0].operation == pfj_pkg::OP_DIAG) ? pay_r[0].vrow_im
                                                            : pay_r[0].vcol_im;

  pfj_unitvec u_uv (
    .clk(clk), .en(en), .x_re(uv_x_re), .x_im(uv_x_im),
    .n_re_r(n_re), .n_im_r(n_im)
  );

  // p = y * vk
  pfj_cmul u_p (
    .clk(clk), .en(en),
    .a(pfj_pkg::ext(pay_r[0].adm_re)), .b(pfj_pkg::ext(pay_r[0].vcol_re)),
    .c(pfj_pkg::neg(pay_r[0].adm_im)), .d(pfj_pkg::ext(pay_r[0].vcol_im)),
    .e(pfj_pkg::ext(pay_r[0].adm_re)), .f(pfj_pkg::ext(pay_r[0].vcol_im)),
    .g(pfj_pkg::ext(pay_r[0].adm_im)), .h(pfj_pkg::ext(pay_r[0].vcol_re)),
    .re_r(p_re), .im_r(p_im)
  );

  // angle operands
  assign pa = pay_r[pfj_pkg::CM_LAT];
  always_comb begin
    if (pa.operation == pfj_pkg::OP_DIAG) begin
      ao[0] = pfj_pkg::ext(pa.vrow_re); ao[1] = pfj_pkg::ext(pa.cur_im);
      ao[2] = pfj_pkg::neg(pa.vrow_im); ao[3] = pfj_pkg::ext(pa.cur_re);
      ao[4] = pfj_pkg::ext(pa.vrow_re); ao[5] = pfj_pkg::ext(pa.cur_re);
      ao[6] = pfj_pkg::ext(pa.vrow_im); ao[7] = pfj_pkg::ext(pa.cur_im);
    end else begin
      ao[0] = pfj_pkg::ext(pa.vrow_im); ao[1] = pfj_pkg::ext(p_re);
      ao[2] = pfj_pkg::neg(pa.vrow_re); ao[3] = pfj_pkg::ext(p_im);
      ao[4] = pfj_pkg::neg(pa.vrow_re); ao[5] = pfj_pkg::ext(p_re);
      ao[6] = pfj_pkg::neg(pa.vrow_im); ao[7] = pfj_pkg::ext(p_im);
    end
  end

  pfj_cmul u_ang (
    .clk(clk), .en(en),
    .a(ao[0]), .b(ao[1]), .c(ao[2]), .d(ao[3]),
    .e(ao[4]), .f(ao[5]), .g(ao[6]), .h(ao[7]),
    .re_r(a_re), .im_r(a_im)
  );

  // align angle with the magnitude path, and unit vector with q
  always_ff @(posedge clk) begin
    if (en) begin
      ang_d_r[0] <= '{re: a_re, im: a_im};
      for (int i = 1; i < UV; i++) ang_d_r[i] <= ang_d_r[i-1];
      n_d_r[0] <= '{re: n_re, im: n_im};
      for (int i = 1; i < pfj_pkg::CM_LAT; i++) n_d_r[i] <= n_d_r[i-1];
    end
  end

  // q = y * unit vector
  pfj_cmul u_q (
    .clk(clk), .en(en),
    .a(pfj_pkg::ext(pay_r[UV].adm_re)), .b(pfj_pkg::ext(n_re)),
    .c(pfj_pkg::neg(pay_r[UV].adm_im)), .d(pfj_pkg::ext(n_im)),
    .e(pfj_pkg::ext(pay_r[UV].adm_re)), .f(pfj_pkg::ext(n_im)),
    .g(pfj_pkg::ext(pay_r[UV].adm_im)), .h(pfj_pkg::ext(n_re)),
    .re_r(q_re), .im_r(q_im)
  );

  // magnitude operands
  assign pm = pay_r[PAY_D];
  always_comb begin
    if (pm.operation == pfj_pkg::OP_DIAG) begin
      mo[0] = pfj_pkg::ext(pm.cur_re); mo[1] = pfj_pkg::ext(n_d_r[pfj_pkg::CM_LAT-1].re);
      mo[2] = pfj_pkg::ext(pm.cur_im); mo[3] = pfj_pkg::ext(n_d_r[pfj_pkg::CM_LAT-1].im);
      mo[4] = pfj_pkg::ext(pm.cur_re); mo[5] = pfj_pkg::ext(n_d_r[pfj_pkg::CM_LAT-1].im);
      mo[6] = pfj_pkg::neg(pm.cur_im); mo[7] = pfj_pkg::ext(n_d_r[pfj_pkg::CM_LAT-1].re);
    end else begin
      mo[0] = pfj_pkg::ext(pm.vrow_re); mo[1] = pfj_pkg::ext(q_re);
      mo[2] = pfj_pkg::ext(pm.vrow_im); mo[3] = pfj_pkg::ext(q_im);
      mo[4] = pfj_pkg::ext(pm.vrow_im); mo[5] = pfj_pkg::ext(q_re);
      mo[6] = pfj_pkg::neg(pm.vrow_re); mo[7] = pfj_pkg::ext(q_im);
    end
  end

  pfj_cmul u_mag (
    .clk(clk), .en(en),
    .a(mo[0]), .b(mo[1]), .c(mo[2]), .d(mo[3]),
    .e(mo[4]), .f(mo[5]), .g(mo[6]), .h(mo[7]),
    .re_r(m_re), .im_r(m_im)
  );

  // result word
  assign out_data.angle_re = ang_d_r[UV-1].re;
  assign out_data.angle_im = ang_d_r[UV-1].im;
  assign out_data.mag_re   = m_re;
  assign out_data.mag_im   = m_im;

`ifndef SYNTHESIS
  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while held");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled pipeline keeps its entry stage
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en |=> v_r[0])
    else $error("entry stage lost a word during stall");
`endif

endmodule

### bench/pfj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfj_checker
// Watches both channels of the jacobian element, computes the expected
// derivative word for each accepted input word and compares results in order.
// ----------------------------------------------------------------------------
module pfj_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pfj_pkg::in_word_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pfj_pkg::out_word_t  out_data,
  output int                  fail_count,
  output int                  pending
);
  import pfj_pkg::*;

  out_word_t deriv_q[$];

  // round half up at FB, saturate to DW
  function automatic data_t round_sat(input logic signed [127:0] s);
    logic signed [127:0] r;
    r = (s + (128'sd1 <<< (FB - 1))) >>> FB;
    if (r > 128'sd2147483647) return data_t'(32'h7fffffff);
    if (r < -128'sd2147483648) return data_t'(32'h80000000);
    return data_t'(r[DW-1:0]);
  endfunction

  function automatic data_t mac2(input logic signed [63:0] a, input logic signed [63:0] b,
                                 input logic signed [63:0] c, input logic signed [63:0] d);
    logic signed [127:0] s;
    s = 128'(a) * 128'(b) + 128'(c) * 128'(d);
    return round_sat(s);
  endfunction

  // floor root of re^2+im^2, at least one lsb
  function automatic logic [63:0] vmag(input logic signed [63:0] re,
                                       input logic signed [63:0] im);
    logic [127:0] s;
    logic [127:0] m;
    logic [127:0] c;
    s = 128'(re * re) + 128'(im * im);
    m = 0;
    for (int b = DW; b >= 0; b--) begin
      c = m | (128'd1 << b);
      if (c * c <= s) m = c;
    end
    return (m == 0) ? 64'd1 : m[63:0];
  endfunction

  // component over magnitude, rounded half away from zero
  function automatic logic signed [63:0] unit_part(input logic signed [63:0] x,
                                                   input logic [63:0] m);
    logic [127:0] ax;
    logic [127:0] q;
    logic [127:0] r;
    ax = (x < 0) ? 128'(-x) : 128'(x);
    q = (ax << FB) / m;
    r = (ax << FB) % m;
    if ((r << 1) >= m) q = q + 1;
    return (x < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic out_word_t jacobian(input in_word_t w);
    out_word_t o;
    logic signed [63:0] yr, yi, vr, vi, kr, ki, ir, ii, pr, pi, nr, ni, qr, qi;
    logic [63:0] m;
    yr = w.adm_re;  yi = w.adm_im;
    vr = w.vrow_re; vi = w.vrow_im;
    kr = w.vcol_re; ki = w.vcol_im;
    ir = w.cur_re;  ii = w.cur_im;
    if (w.operation == OP_OFFDIAG) begin
      pr = mac2(yr, kr, -yi, ki);
      pi = mac2(yr, ki, yi, kr);
      m = vmag(kr, ki);
      nr = unit_part(kr, m);
      ni = unit_part(ki, m);
      qr = mac2(yr, nr, -yi, ni);
      qi = mac2(yr, ni, yi, nr);
      o.angle_re = mac2(vi, pr, -vr, pi);
      o.angle_im = mac2(-vr, pr, -vi, pi);
      o.mag_re   = mac2(vr, qr, vi, qi);
      o.mag_im   = mac2(vi, qr, -vr, qi);
    end else begin
      m = vmag(vr, vi);
      nr = unit_part(vr, m);
      ni = unit_part(vi, m);
      o.angle_re = mac2(vr, ii, -vi, ir);
      o.angle_im = mac2(vr, ir, vi, ii);
      o.mag_re   = mac2(ir, nr, ii, ni);
      o.mag_im   = mac2(ir, ni, -ii, nr);
    end
    return o;
  endfunction

  // predict on input words, compare on result words
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) deriv_q.insert(deriv_q.size(), jacobian(in_data));
      if (out_valid && out_ready) begin
        if (deriv_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = deriv_q.pop_front();
          if (e.angle_re !== out_data.angle_re)
            $error("angle_re exp %h got %h", e.angle_re, out_data.angle_re);
          if (e.angle_im !== out_data.angle_im)
            $error("angle_im exp %h got %h", e.angle_im, out_data.angle_im);
          if (e.mag_re !== out_data.mag_re)
            $error("mag_re exp %h got %h", e.mag_re, out_data.mag_re);
          if (e.mag_im !== out_data.mag_im)
            $error("mag_im exp %h got %h", e.mag_im, out_data.mag_im);
          if (e !== out_data) fail_count <= fail_count + 1;
        end
      end
    end
    pending <= deriv_q.size();
  end
endmodule

### bench/tb_power_flow_jacobian_element.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_flow_jacobian_element
// Drives directed and random words into the jacobian element with random
// idling and back-pressure; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_power_flow_jacobian_element;
  import pfj_pkg::*;

  localparam int N_RAND = 1614;
  localparam int WD_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  int fail_count, pending;
  int idle_cnt;
  bit quiet_out, long_hold;

  power_flow_jacobian_element dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  pfj_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // edge-heavy field values
  function automatic data_t pick_val();
    case ($urandom_range(0, 7))
      0: return data_t'(32'h80000000);
      1: return data_t'(32'h7fffffff);
      2: return data_t'(0);
      3: return data_t'($signed($urandom_range(0, 262143)) - 131072);
      4: return data_t'($signed($urandom_range(0, 1023)) - 512);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.operation = op_t'($urandom_range(0, 1));
    w.adm_re = pick_val();  w.adm_im = pick_val();
    w.vrow_re = pick_val(); w.vrow_im = pick_val();
    w.vcol_re = pick_val(); w.vcol_im = pick_val();
    w.cur_re = pick_val();  w.cur_im = pick_val();
    return w;
  endfunction

  function automatic in_word_t fill_word(input op_t op, input data_t v);
    in_word_t w;
    w.operation = op;
    w.adm_re = v; w.adm_im = v; w.vrow_re = v; w.vrow_im = v;
    w.vcol_re = v; w.vcol_im = v; w.cur_re = v; w.cur_im = v;
    return w;
  endfunction

  // offer one word, hold until accepted
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap(input bit allow);
    if (allow && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        out_ready <= 1'b1;
        long_hold = 0;
      end else if (!quiet_out && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet_out = 0; long_hold = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero voltage, unit values, both operations
    for (int op = 0; op < 2; op++) begin
      send_word(fill_word(op_t'(op), data_t'(32'h80000000)));
      send_word(fill_word(op_t'(op), data_t'(32'h7fffffff)));
      send_word(fill_word(op_t'(op), data_t'(0)));
      send_word(fill_word(op_t'(op), data_t'(32'h00010000)));
      send_word(fill_word(op_t'(op), data_t'(-32'sh00010000)));
      w = fill_word(op_t'(op), data_t'(32'h00010000));
      w.vcol_re = 0; w.vcol_im = 0; w.vrow_re = 0; w.vrow_im = 0;
      send_word(w);
      w = fill_word(op_t'(op), data_t'(32'h7fffffff));
      w.vcol_im = data_t'(32'h80000000); w.vrow_im = data_t'(32'h80000000);
      send_word(w);
      w = fill_word(op_t'(op), data_t'(1));
      w.vcol_im = 0; w.vrow_im = 0;
      send_word(w);
    end

    // fill the pipeline while results are held off
    long_hold = 1;
    for (int i = 0; i < 120; i++) send_word(rand_word());

    // pause until the pipeline drains
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < N_RAND; i++) begin
      if (i > N_RAND - 200) quiet_out = 1;
      send_word(rand_word());
      sender_gap(i <= N_RAND - 200);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (OUT_T + 10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
